>>> src/iad_pkg.sv
// Shared types and constants for the inactivity alarm detector.
// Used by every module in src; depends on nothing else.
package iad_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] THRESHOLD_RESET = 16'd2458;
	localparam logic [31:0] TIMEOUT_RESET   = 32'd30000;

	// Square root iteration: one result bit per step, 16 steps.
	localparam int          ROOT_STEPS = 16;
	localparam logic [31:0] ROOT_BIT0  = 32'h4000_0000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_MOVE,
		ST_ALARM
	} state_t;

endpackage

>>> src/iad_sqsum.sv
// Sum of squares of three signed axis samples using one shared multiplier.
// Depends on iad_pkg.
module iad_sqsum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] axis_x,
	input  logic [15:0] axis_y,
	input  logic [15:0] axis_z,
	output logic        done,
	output logic [31:0] sum
);
	import iad_pkg::*;

	logic [16:0] op0_q, op1_q, op2_q;
	logic [31:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] prod;

	// Absolute value of a 16-bit two's complement sample, 17 bits wide.
	function automatic logic [16:0] abs17(input logic [15:0] v);
		logic [16:0] ext;
		ext = {v[15], v};
		return v[15] ? (17'd0 - ext) : ext;
	endfunction

	// The shared multiplier always squares the head of the operand queue.
	assign prod = op0_q * op0_q;

	// Control: three accumulate steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the operands, then shift them through the multiplier.
	always_ff @(posedge clk) begin
		if (start) begin
			op0_q <= abs17(axis_x);
			op1_q <= abs17(axis_y);
			op2_q <= abs17(axis_z);
			acc_q <= 32'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod[31:0];
			op0_q <= op1_q;
			op1_q <= op2_q;
			op2_q <= 17'd0;
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

>>> src/iad_isqrt.sv
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on iad_pkg.
module iad_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);
	import iad_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	// Shared add and compare: try root + bit against the remainder.
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign fits  = {1'b0, rem_q} >= trial;

	// Control: run until the lowest bit position has been processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: one step of the digit-by-digit root per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= 32'd0;
			bit_q  <= ROOT_BIT0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= rem_q - trial[31:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[15:0];

endmodule

>>> src/inactivity_alarm_detector.sv
// Inactivity alarm detector: magnitude, movement check and alarm latch.
// An input transaction is squared axis by axis on the shared multiplier, then the
// 16 square root steps run, then the movement and alarm decisions are made.
// One item is in work at a time, so a new transaction waits for the last to finish.
// The output register lets the next item start while a result waits.
// Asynchronous active-low reset clears state; thresholds return to defaults.
module inactivity_alarm_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   accel_x,
	input  logic [15:0]                   accel_y,
	input  logic [15:0]                   accel_z,
	input  logic [31:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   magnitude,
	output logic [15:0]                   change,
	output logic                          movement,
	output logic                          alarm_fire,
	output logic                          alarm_active,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [iad_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [iad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import iad_pkg::*;

	state_t      state_q, state_d;
	logic [15:0] thr_q;
	logic [31:0] tmo_q;
	logic [15:0] prev_mag_q;
	logic [31:0] last_move_q;
	logic        latch_q;
	logic [31:0] now_q;
	logic [15:0] mag_q;
	logic [15:0] change_q;
	logic        moved_q;
	logic        out_valid_q;
	logic [15:0] out_mag_q;
	logic [15:0] out_change_q;
	logic        out_moved_q;
	logic        out_fire_q;
	logic        out_active_q;

	logic        in_take;
	logic        sq_start, sq_done;
	logic [31:0] sq_sum;
	logic        rt_done;
	logic [15:0] rt_root;
	logic        out_free;
	logic        load_out;
	logic [15:0] diff;
	logic [31:0] elapsed;
	logic        fire;

	// Shared multiplier for the sum of squares.
	iad_sqsum u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.axis_x (accel_x),
		.axis_y (accel_y),
		.axis_z (accel_z),
		.done   (sq_done),
		.sum    (sq_sum)
	);

	// Iterative square root.
	iad_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_done),
		.radicand (sq_sum),
		.done     (rt_done),
		.root     (rt_root)
	);

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_take) state_d = ST_SQUARE;
			ST_SQUARE: if (sq_done) state_d = ST_ROOT;
			ST_ROOT:   if (rt_done) state_d = ST_MOVE;
			ST_MOVE:   state_d = ST_ALARM;
			ST_ALARM:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = 1'b1;
		sq_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				sq_start = in_valid;
			end
			ST_ALARM: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Config registers; the user writes only while the block is idle, unchecked.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			tmo_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[15:0];
				REG_TIMEOUT:   tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the timestamp of the accepted transaction.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q <= now_ms;
		end
	end

	// Movement decision: change against the previous magnitude.
	assign diff = (rt_root >= prev_mag_q) ? (rt_root - prev_mag_q) : (prev_mag_q - rt_root);

	always_ff @(posedge clk) begin
		if (state_q == ST_MOVE) begin
			mag_q    <= rt_root;
			change_q <= diff;
			moved_q  <= diff > thr_q;
		end
	end

	// Alarm decision uses the movement time already updated in this item.
	assign elapsed = now_q - last_move_q;
	assign fire    = !latch_q && (elapsed > tmo_q);

	// Detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mag_q  <= 16'd0;
			last_move_q <= 32'd0;
			latch_q     <= 1'b0;
		end else if (state_q == ST_MOVE) begin
			prev_mag_q <= rt_root;
			if (diff > thr_q) begin
				last_move_q <= now_q;
				latch_q     <= 1'b0;
			end
		end else if (load_out && fire) begin
			latch_q <= 1'b1;
		end
	end

	// Output register: holds the result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_mag_q    <= mag_q;
			out_change_q <= change_q;
			out_moved_q  <= moved_q;
			out_fire_q   <= fire;
			out_active_q <= latch_q || fire;
		end
	end

	assign out_valid    = out_valid_q;
	assign magnitude    = out_mag_q;
	assign change       = out_change_q;
	assign movement     = out_moved_q;
	assign alarm_fire   = out_fire_q;
	assign alarm_active = out_active_q;

endmodule

>>> bench/inactivity_alarm_detector_tb.sv
// Self-checking testbench for the inactivity alarm detector.
// Holds its own predictor of magnitude, movement and alarm latch; depends only on
// iad_pkg and the inactivity_alarm_detector module.
module inactivity_alarm_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iad_pkg::*;

	// Indexes that map to no register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	localparam int SETTLE_CYCLES  = 30;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int TIMEOUT_NS     = 2_000_000;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [31:0] now;
	} sample_t;

	typedef struct packed {
		logic [15:0] magnitude;
		logic [15:0] change;
		logic        movement;
		logic        alarm_fire;
		logic        alarm_active;
	} result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [15:0]           accel_x   = '0;
	logic [15:0]           accel_y   = '0;
	logic [15:0]           accel_z   = '0;
	logic [31:0]           now_ms    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [15:0]           magnitude;
	logic [15:0]           change;
	logic                  movement;
	logic                  alarm_fire;
	logic                  alarm_active;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor state and its copy of the configuration registers.
	logic [15:0] thr_q      = THRESHOLD_RESET;
	logic [31:0] tmo_q      = TIMEOUT_RESET;
	logic [15:0] prev_mag   = '0;
	logic [31:0] last_move  = '0;
	logic        latch_q    = 1'b0;

	result_t     expected_results [$];
	int          fail_count     = 0;
	int          tx_idle_pct    = 38;
	int          rx_idle_pct    = 51;
	int          holdoff_reqs   = 0;
	int          holdoff_served = 0;
	int          hold_count     = 0;
	logic [31:0] clock_ms       = '0;

	inactivity_alarm_detector DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.magnitude    (magnitude),
		.change       (change),
		.movement     (movement),
		.alarm_fire   (alarm_fire),
		.alarm_active (alarm_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Absolute value of a two's complement axis reading; -32768 needs the 17th bit.
	function automatic logic [16:0] axis_abs(input logic [15:0] v);
		logic signed [16:0] sv;
		sv = $signed(v);
		return (sv < 0) ? 17'(-sv) : 17'(sv);
	endfunction

	// Floor square root, one result bit per iteration.
	function automatic logic [15:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] probe;
		rem   = n;
		root  = '0;
		probe = 64'h4000_0000;
		for (int k = 0; k < ROOT_STEPS; k++) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[15:0];
	endfunction

	// Advances the predictor by one sample and returns the result it implies.
	function automatic result_t magnitude_alarm_step(input sample_t s);
		result_t     r;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] az;
		logic [31:0] elapsed;
		ax = 64'(axis_abs(s.x));
		ay = 64'(axis_abs(s.y));
		az = 64'(axis_abs(s.z));
		r.magnitude = floor_sqrt(ax * ax + ay * ay + az * az);
		r.change = (r.magnitude >= prev_mag) ? r.magnitude - prev_mag
		                                     : prev_mag - r.magnitude;
		prev_mag = r.magnitude;
		r.movement = (r.change > thr_q);
		// Movement restarts the quiet interval before the timeout is judged.
		if (r.movement) begin
			last_move = s.now;
			latch_q   = 1'b0;
		end
		elapsed = s.now - last_move;
		r.alarm_fire = !latch_q && (elapsed > tmo_q);
		if (r.alarm_fire) begin
			latch_q = 1'b1;
		end
		r.alarm_active = latch_q;
		return r;
	endfunction

	function automatic sample_t make_sample(input int x, input int y, input int z,
	                                        input logic [31:0] t);
		sample_t s;
		s.x   = 16'(x);
		s.y   = 16'(y);
		s.z   = 16'(z);
		s.now = t;
		return s;
	endfunction

	function automatic int wobble(input int amp);
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	// Offers one sample and records its expected result once the transaction lands.
	// Valid stays high afterward until a later gap or quiesce drops it.
	task automatic offer_sample(input sample_t s);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x  <= s.x;
		accel_y  <= s.y;
		accel_z  <= s.z;
		now_ms   <= s.now;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(magnitude_alarm_step(s));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESHOLD: thr_q = data[15:0];
			REG_TIMEOUT:   tmo_q = data;
			default: ;
		endcase
	endtask

	// Drops both request lines and waits until every result is back.
	task automatic quiesce();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Upper threshold bits carry junk; only the low 16 bits are kept.
	task automatic configure(input logic [15:0] thr, input logic [31:0] tmo);
		quiesce();
		write_reg(REG_THRESHOLD, {16'($urandom), thr});
		write_reg(REG_TIMEOUT, tmo);
		cfg_valid <= 1'b0;
	endtask

	// Receiver stall: random, or held for a long stretch on request.
	always @(posedge clk) begin
		if (hold_count != 0) begin
			out_stall  <= 1'b1;
			hold_count <= hold_count - 1;
		end else if (holdoff_served != holdoff_reqs) begin
			out_stall      <= 1'b1;
			hold_count     <= HOLDOFF_CYCLES;
			holdoff_served <= holdoff_served + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no sample outstanding");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("magnitude", want.magnitude, magnitude);
				check_field("change", want.change, change);
				check_field("movement", want.movement, movement);
				check_field("alarm_fire", want.alarm_fire, alarm_fire);
				check_field("alarm_active", want.alarm_active, alarm_active);
			end
		end
	end

	// Reset defaults: first sample against zero, a timeout, and movement that clears the alarm.
	task automatic test_reset_defaults();
		offer_sample(make_sample(0, 0, 0, 32'd5));
		offer_sample(make_sample(16384, 0, 0, 32'd100));
		offer_sample(make_sample(16384, 100, 0, 32'd20000));
		offer_sample(make_sample(0, 16384, 0, 32'd30101));
		offer_sample(make_sample(0, 0, 16384, 32'd40000));
		offer_sample(make_sample(-32768, 0, 0, 32'd90000));
	endtask

	task automatic test_field_extremes();
		offer_sample(make_sample(32767, 32767, 32767, 32'd90100));
		offer_sample(make_sample(-32768, -32768, -32768, 32'd90200));
		offer_sample(make_sample(-1, -1, -1, 32'd90300));
		offer_sample(make_sample(-32768, 32767, 0, 32'd90400));
		offer_sample(make_sample(21845, -21846, 1, 32'd90500));
	endtask

	// Elapsed time across the 32-bit wrap and after a backward step.
	task automatic test_timestamp_wrap();
		configure(16'd2458, 32'd1000);
		offer_sample(make_sample(0, 0, 0, 32'hFFFF_FF00));
		offer_sample(make_sample(0, 0, 10, 32'hFFFF_FF80));
		offer_sample(make_sample(0, 0, 0, 32'h0000_0300));
		offer_sample(make_sample(16384, 0, 0, 32'h0000_1000));
		offer_sample(make_sample(16384, 0, 0, 32'h0000_0800));
	endtask

	task automatic test_zero_threshold();
		configure(16'd0, 32'd5000);
		offer_sample(make_sample(100, 0, 0, 32'd10));
		offer_sample(make_sample(100, 0, 0, 32'd20));
		offer_sample(make_sample(101, 0, 0, 32'd30));
	endtask

	// Largest timeout never fires; largest threshold never sees movement.
	task automatic test_max_timeout();
		configure(16'hFFFF, 32'hFFFF_FFFF);
		offer_sample(make_sample(32767, 32767, 32767, 32'd1000));
		offer_sample(make_sample(0, 0, 0, 32'd1001));
		offer_sample(make_sample(-32768, -32768, -32768, 32'd995));
	endtask

	task automatic test_unused_index();
		quiesce();
		write_reg(REG_UNUSED_A, $urandom);
		write_reg(REG_UNUSED_B, $urandom);
		cfg_valid <= 1'b0;
		offer_sample(make_sample(0, 0, 0, 32'd2000));
		offer_sample(make_sample(0, -32768, 0, 32'd3000));
	endtask

	// Receiver holds off long enough that the block fills and stalls its input.
	task automatic test_backpressure();
		configure(16'd300, 32'd2500);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holdoff_reqs++;
		repeat (30) begin
			clock_ms += $urandom_range(0, 900);
			offer_sample(make_sample(8000 + wobble(400), -3000 + wobble(400),
			                         12000 + wobble(400), clock_ms));
		end
	endtask

	// Mostly quiet runs with jitter that let the alarm build up, plus bursts and noise.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
		logic [15:0] thr;
		logic [31:0] tmo;
		logic [31:0] step_max;
		int          sent;
		int          kind;
		int          len;
		int          jit;
		int          bx;
		int          by;
		int          bz;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		clock_ms = $urandom;
		for (int seg = 0; seg < 4; seg++) begin
			case ($urandom_range(0, 6))
				0: thr = 16'd0;
				1: thr = 16'd1;
				2: thr = 16'd16;
				3: thr = 16'd300;
				4: thr = THRESHOLD_RESET;
				5: thr = 16'hFFFF;
				default: thr = 16'($urandom_range(0, 4000));
			endcase
			case ($urandom_range(0, 6))
				0: tmo = 32'd0;
				1: tmo = 32'd1;
				2: tmo = 32'd800;
				3: tmo = 32'd3000;
				4: tmo = TIMEOUT_RESET;
				5: tmo = 32'hFFFF_FFFF;
				default: tmo = $urandom_range(0, 20000);
			endcase
			configure(thr, tmo);
			step_max = (tmo_q <= 40000) ? tmo_q / 4 + 20 : 32'd5000;
			while (sent < count * (seg + 1) / 4) begin
				kind = $urandom_range(0, 99);
				if (kind < 65) begin
					// Quiet run around a fixed orientation, sometimes near the wrap.
					bx = int'($urandom_range(0, 60000)) - 30000;
					by = int'($urandom_range(0, 60000)) - 30000;
					bz = int'($urandom_range(0, 60000)) - 30000;
					case ($urandom_range(0, 3))
						0: jit = 0;
						1: jit = 3;
						2: jit = 40;
						default: jit = 1024;
					endcase
					if ($urandom_range(0, 9) == 0) begin
						clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
					end
					len = $urandom_range(4, 24);
					repeat (len) begin
						clock_ms += $urandom_range(0, step_max);
						offer_sample(make_sample(bx + wobble(jit), by + wobble(jit),
						                         bz + wobble(jit), clock_ms));
					end
				end else if (kind < 82) begin
					// Movement burst with full-range readings.
					len = $urandom_range(1, 4);
					repeat (len) begin
						clock_ms += $urandom_range(0, step_max);
						offer_sample(make_sample($urandom, $urandom, $urandom, clock_ms));
					end
				end else begin
					// Noise: random readings and arbitrary timestamps.
					len = $urandom_range(1, 3);
					repeat (len) begin
						clock_ms = $urandom;
						offer_sample(make_sample($urandom, $urandom, $urandom, clock_ms));
					end
				end
				sent += len;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_timestamp_wrap();
		test_zero_threshold();
		test_max_timeout();
		test_unused_index();
		test_backpressure();
		test_random_traffic(38, 51, 280);
		test_random_traffic(51, 38, 280);
		test_random_traffic(0, 0, 230);

		// Drain the last results, then give the block time to go quiet.
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && expected_results.size() != 0; w++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
